### hdl/byte_playfair_cipher_macros.svh
// Assertion macros shared by the byte Playfair cipher RTL.
`ifndef BYTE_PLAYFAIR_CIPHER_MACROS_SVH
`define BYTE_PLAYFAIR_CIPHER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BPF_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Implication checked at the same clock edge.
`define BPF_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/bpf_pkg.sv
// Types and constants of the byte Playfair cipher.
`default_nettype none

package bpf_pkg;

    localparam int CELL_W    = 8;
    localparam int GRID_SIDE = 16;
    localparam int COL_W     = $clog2(GRID_SIDE);
    localparam logic [CELL_W-1:0] PAD_BYTE = 8'hFF;
    localparam logic [COL_W-1:0]  STEP_FWD = COL_W'(1);
    localparam logic [COL_W-1:0]  STEP_REV = COL_W'(GRID_SIDE - 1);

    // What one pipelined pair turns into at the output.
    typedef enum logic [1:0] {
        KIND_ENC2,   // enciphered pair, two beats
        KIND_ENC4,   // doubled last byte: same pair twice, four beats
        KIND_DEC,    // deciphered pair, pad bytes dropped
        KIND_ODD     // unpaired decrypt byte, end marker with error
    } t_pair_kind;

    typedef struct packed {
        logic              en;
        logic [CELL_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_lut_wr;

endpackage

`default_nettype wire

### hdl/bpf_lut.sv
// 256x8 table memory, one write and two registered reads, identity after reset.
`default_nettype none

module bpf_lut
    import bpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lut_wr           i_wr,
    input  wire logic              i_rd_en,
    input  wire logic [CELL_W-1:0] i_rd_addr0,
    input  wire logic [CELL_W-1:0] i_rd_addr1,
    output logic      [CELL_W-1:0] o_rd_data0,
    output logic      [CELL_W-1:0] o_rd_data1
);

    localparam int DEPTH = 1 << CELL_W;

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_written;

    logic [CELL_W-1:0] r_rd_data0, r_rd_data1;
    logic [CELL_W-1:0] r_rd_addr0, r_rd_addr1;
    logic              r_rd_hit0,  r_rd_hit1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.en) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    // reads see the contents from before a write at the same edge
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data0 <= r_mem[i_rd_addr0];
            r_rd_data1 <= r_mem[i_rd_addr1];
            r_rd_addr0 <= i_rd_addr0;
            r_rd_addr1 <= i_rd_addr1;
            r_rd_hit0  <= r_written[i_rd_addr0] && !(i_wr.en && !i_rst_n);
            r_rd_hit1  <= r_written[i_rd_addr1] && !(i_wr.en && !i_rst_n);
        end
    end

    // never-written cell reads as its own index
    assign o_rd_data0 = r_rd_hit0 ? r_rd_data0 : r_rd_addr0;
    assign o_rd_data1 = r_rd_hit1 ? r_rd_data1 : r_rd_addr1;

endmodule

`default_nettype wire

### hdl/byte_playfair_cipher.sv
// Byte Playfair cipher over a 16x16 table: pairing, lookup pipeline, output sequencer.
// Path: a pair's cover-table read loads stage 1, then its table read loads the output stage 2.
// Throughput: one input beat per cycle when stage 1 is free, table writes included (no result);
// the sequencer drains one beat per ready cycle (2 a pair, 4 for a doubled last encrypt byte).
// Reset (synchronous, active low): both tables read as identity at once through per-cell
// written flags, held byte dropped, mode back to encrypt.
`default_nettype none

module byte_playfair_cipher
    import bpf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration: decrypt_mode
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [7:0] cell_index, [15:8] data_byte
    input  wire logic        i_s_tuser,   // [0] req_type
    input  wire logic        i_s_tlast,   // msg_last
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_byte
    output logic [1:0]       o_m_tuser,   // [0] has_byte, [1] odd_error
    output logic             o_m_tlast    // out_last
);

`include "byte_playfair_cipher_macros.svh"

    logic [CELL_W-1:0] in_cell, in_byte;
    logic              accept, msg_beat, tbl_beat;

    logic              r_mode;
    logic              r_held_vld, n_held_vld;
    logic [CELL_W-1:0] r_held_byte, n_held_byte;

    logic              s1_load;
    t_pair_kind        n_kind;
    logic              n_last;
    logic [CELL_W-1:0] pair_a, pair_b;

    logic              r_s1_vld;
    t_pair_kind        r_s1_kind;
    logic              r_s1_last;

    logic              r_s2_vld;
    t_pair_kind        r_s2_kind;
    logic              r_s2_last;
    logic [1:0]        r_idx;

    logic              s1_move, s1_free, s2_free, s2_done, beat_out, final_beat;

    t_lut_wr           tbl_wr, cov_wr;
    logic [CELL_W-1:0] cell_a, cell_b, ct_addr_a, ct_addr_b, res_x, res_y;
    logic [COL_W-1:0]  row_a, col_a, row_b, col_b, step;
    logic [COL_W-1:0]  n_row_a, n_col_a, n_row_b, n_col_b;

    logic [2:0]        s2_cnt;
    logic              keep_x, keep_y;

    assign in_cell  = i_s_tdata[7:0];
    assign in_byte  = i_s_tdata[15:8];
    assign accept   = i_s_tvalid && o_s_tready;
    assign msg_beat = accept && i_s_tuser;
    assign tbl_beat = accept && !i_s_tuser;

    // ---------------- pairing at the input ----------------
    always_comb begin
        n_held_vld  = r_held_vld;
        n_held_byte = r_held_byte;
        s1_load     = 1'b0;
        n_kind      = KIND_ENC2;
        n_last      = i_s_tlast;
        pair_a      = in_byte;
        pair_b      = PAD_BYTE;
        if (msg_beat) begin
            if (!r_mode) begin
                if (!r_held_vld) begin
                    if (i_s_tlast) begin
                        s1_load = 1'b1;
                    end else begin
                        n_held_vld  = 1'b1;
                        n_held_byte = in_byte;
                    end
                end else if (r_held_byte == in_byte) begin
                    // doubled byte: (held, pad) now; held stays the same value unless this byte is last
                    s1_load = 1'b1;
                    if (i_s_tlast) begin
                        n_kind     = KIND_ENC4;
                        n_held_vld = 1'b0;
                    end
                end else begin
                    s1_load    = 1'b1;
                    pair_a     = r_held_byte;
                    pair_b     = in_byte;
                    n_held_vld = 1'b0;
                end
            end else begin
                if (!r_held_vld) begin
                    if (i_s_tlast) begin
                        s1_load = 1'b1;
                        n_kind  = KIND_ODD;
                    end else begin
                        n_held_vld  = 1'b1;
                        n_held_byte = in_byte;
                    end
                end else begin
                    s1_load    = 1'b1;
                    n_kind     = KIND_DEC;
                    pair_a     = r_held_byte;
                    pair_b     = in_byte;
                    n_held_vld = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_held_vld <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_mode     <= i_cfg_wr_data;
            r_held_vld <= 1'b0;
        end else begin
            r_held_vld <= n_held_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_byte <= n_held_byte;
    end

    // ---------------- tables ----------------
    assign tbl_wr = '{en: tbl_beat, addr: in_cell, data: in_byte};
    assign cov_wr = '{en: tbl_beat, addr: in_byte, data: in_cell};

    bpf_lut u_cov (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (cov_wr),
        .i_rd_en    (s1_load),
        .i_rd_addr0 (pair_a),
        .i_rd_addr1 (pair_b),
        .o_rd_data0 (cell_a),
        .o_rd_data1 (cell_b)
    );

    bpf_lut u_tbl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_en    (s1_move),
        .i_rd_addr0 (ct_addr_a),
        .i_rd_addr1 (ct_addr_b),
        .o_rd_data0 (res_x),
        .o_rd_data1 (res_y)
    );

    // ---------------- stage 1: Playfair rule on cell positions ----------------
    assign row_a = cell_a[CELL_W-1:COL_W];
    assign col_a = cell_a[COL_W-1:0];
    assign row_b = cell_b[CELL_W-1:COL_W];
    assign col_b = cell_b[COL_W-1:0];
    assign step  = (r_s1_kind == KIND_DEC) ? STEP_REV : STEP_FWD;

    always_comb begin
        n_row_a = row_a;
        n_row_b = row_b;
        n_col_a = col_b;
        n_col_b = col_a;
        if (row_a == row_b) begin
            n_col_a = col_a + step;   // wraps modulo the grid side
            n_col_b = col_b + step;
        end else if (col_a == col_b) begin
            n_col_a = col_a;
            n_col_b = col_b;
            n_row_a = row_a + step;
            n_row_b = row_b + step;
        end
    end

    assign ct_addr_a = {n_row_a, n_col_a};
    assign ct_addr_b = {n_row_b, n_col_b};

    // ---------------- pipeline control ----------------
    assign s2_free = !r_s2_vld || s2_done;
    assign s1_move = r_s1_vld && s2_free;
    assign s1_free = !r_s1_vld || s1_move;
    // table writes also wait here so an older pair never reads a newer cell
    assign o_s_tready = s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_idx    <= 2'd0;
        end else begin
            if (s1_load) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_s2_vld <= 1'b1;
            end else if (s2_done) begin
                r_s2_vld <= 1'b0;
            end
            if (beat_out) begin
                r_idx <= final_beat ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind <= n_kind;
            r_s1_last <= n_last;
        end
        if (s1_move) begin
            r_s2_kind <= r_s1_kind;
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------- stage 2: output sequencer ----------------
    assign keep_x = res_x != PAD_BYTE;
    assign keep_y = res_y != PAD_BYTE;

    always_comb begin
        unique case (r_s2_kind)
            KIND_ENC2: s2_cnt = 3'd2;
            KIND_ENC4: s2_cnt = 3'd4;
            KIND_ODD:  s2_cnt = 3'd1;
            KIND_DEC: begin
                s2_cnt = {2'b00, keep_x} + {2'b00, keep_y};
                if (!keep_x && !keep_y && r_s2_last) begin
                    s2_cnt = 3'd1;   // bare end marker
                end
            end
            default:   s2_cnt = 3'd0;
        endcase
    end

    assign final_beat = {1'b0, r_idx} == (s2_cnt - 3'd1);
    assign o_m_tvalid = r_s2_vld && (s2_cnt != 3'd0);
    assign beat_out   = o_m_tvalid && i_m_tready;
    assign s2_done    = r_s2_vld && ((s2_cnt == 3'd0) || (beat_out && final_beat));
    assign o_m_tlast  = r_s2_last && final_beat;

    always_comb begin
        o_m_tdata = '0;
        o_m_tuser = 2'b00;
        unique case (r_s2_kind)
            KIND_ENC2, KIND_ENC4: begin
                o_m_tdata = r_idx[0] ? res_y : res_x;
                o_m_tuser = 2'b01;
            end
            KIND_ODD: begin
                o_m_tuser = 2'b10;
            end
            KIND_DEC: begin
                if ((r_idx == 2'd0) && keep_x) begin
                    o_m_tdata = res_x;
                    o_m_tuser = 2'b01;
                end else if (keep_y) begin
                    o_m_tdata = res_y;
                    o_m_tuser = 2'b01;
                end
            end
            default: begin
                o_m_tdata = '0;
                o_m_tuser = 2'b00;
            end
        endcase
    end

    // ---------------- assertions ----------------
    `BPF_ASSERT_IMPLIES(a_marker_is_last, o_m_tvalid && !o_m_tuser[0], o_m_tlast,
        "end marker beat without tlast")
    `BPF_ASSERT_IMPLIES(a_stall_means_full, !o_s_tready, r_s1_vld && r_s2_vld,
        "input stalled with a free pipeline slot")
    `BPF_ASSERT_IMPLIES(a_idx_in_range, r_s2_vld && (s2_cnt != 3'd0),
        {1'b0, r_idx} < s2_cnt, "output beat index past the pair's beat count")
    `BPF_ASSERT_IMPLIES(a_odd_is_last, r_s1_vld && (r_s1_kind == KIND_ODD), r_s1_last,
        "odd-length marker not flagged as message end")
    `BPF_ASSERT_ALWAYS(a_no_load_when_busy, !(s1_load && !s1_free),
        "pair loaded into an occupied stage")

endmodule

`default_nettype wire
